FILE: rtl/kbsa_pkg.sv
// Package for the keyed busy slot admission block.
// Holds field widths, status and mode codes and register indexes.
// No dependencies; imported by rtl/keyed_busy_slot_admission.sv.
package kbsa_pkg;

    localparam int KEY_W       = 64;
    localparam int CNT6_W      = 6;
    localparam int WAIT_W      = 16;
    localparam int HELD_W      = 5;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 152;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;
    localparam int SLOT_COUNT_DEFAULT = 32;

    localparam logic [CNT6_W-1:0] CNT6_MAX = 6'd63;

    localparam logic [STATUS_W-1:0] ST_GRANT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RETRY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_GIVEUP = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSE = 2'd3;

    localparam logic [MODE_W-1:0] MODE_PLAIN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KEYED   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_BUSY     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_WAITING  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WAIT_TIMEOUT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_TABLE_EN = 2'd3;

endpackage

FILE: rtl/keyed_busy_slot_admission.sv
// Keyed busy slot admission: one module with a key table memory and a scan sequencer.
// Depends on rtl/kbsa_pkg.sv.
// Plain acquire and release skip the scan and go straight to the decide state.
// Keyed acquire scans the key table one slot per cycle through the single read port
// of the key memory; one item is in work at a time.
// The result register lets the next transaction enter while a result waits.
// rst_n at once clears state, config, counts, occupancy, out valid; keys not cleared.
module keyed_busy_slot_admission #(
    parameter int SLOT_COUNT = kbsa_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [kbsa_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [kbsa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // key_high[63:0], key_low[127:64], lock_request[128], wait_time[144:129],
    // held_slot[149:145], zero fill[151:150]
    input  logic [kbsa_pkg::S_TDATA_W-1:0]    s_tdata,
    // mode[1:0]
    input  logic [kbsa_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[1:0], granted_slot[6:2], arm_retry_timer[7]
    output logic [kbsa_pkg::M_TDATA_W-1:0]    m_tdata
);
    import kbsa_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int IW = $clog2(SLOT_COUNT + 1);
    localparam int CW = (IW > CNT6_W) ? IW : CNT6_W;
    localparam logic [CW-1:0] SLOT_COUNT_C = CW'(SLOT_COUNT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t state_reg, state_next;

    logic [CNT6_W-1:0] max_busy_reg;
    logic [WAIT_W-1:0] max_waiting_reg;
    logic [WAIT_W-1:0] wait_timeout_reg;
    logic              key_table_en_reg;

    logic [CNT6_W-1:0] busy_reg, busy_next;
    logic [WAIT_W-1:0] waiting_reg, waiting_next;
    logic [CNT6_W-1:0] keyed_reg, keyed_next;
    logic              occ_reg [SLOT_COUNT];
    logic              occ_next [SLOT_COUNT];

    logic [MODE_W-1:0] mode_reg;
    logic [KEY_W-1:0]  key_high_reg;
    logic [KEY_W-1:0]  key_low_reg;
    logic              lock_reg;
    logic [WAIT_W-1:0] wait_time_reg;
    logic [HELD_W-1:0] held_reg;

    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] seen_reg, seen_next;
    logic          dup_reg, dup_next;
    logic          have_free_reg, have_free_next;
    logic [SW-1:0] free_reg, free_next;

    logic [2*KEY_W-1:0] key_mem [SLOT_COUNT];
    logic [2*KEY_W-1:0] rd_key_reg;
    logic [SW-1:0]      rd_addr;
    logic               mem_wr;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [HELD_W-1:0]   slot_reg, slot_next;
    logic                arm_reg, arm_next;

    logic [CW-1:0] max_busy_ext;
    logic [CW-1:0] limit;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] seen_step;
    logic [CW-1:0] held_ext;
    logic          occ_cur;
    logic          hit;
    logic          out_free;
    logic          to_wait;
    logic          store;

    logic [STATUS_W-1:0] wl_status;
    logic                wl_arm;
    logic [WAIT_W-1:0]   wl_waiting;

    assign s_tready     = (state_reg == ST_IDLE);
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {arm_reg, slot_reg, status_reg};
    assign out_free     = !out_valid_reg || m_tready;
    assign max_busy_ext = CW'(max_busy_reg);
    assign limit        = (max_busy_ext < SLOT_COUNT_C) ? max_busy_ext : SLOT_COUNT_C;
    assign idx_inc      = idx_reg + CW'(1);
    assign occ_cur      = occ_reg[idx_reg[SW-1:0]];
    assign hit          = occ_cur && (rd_key_reg == {key_high_reg, key_low_reg});
    assign seen_step    = seen_reg + CW'(occ_cur && !hit);
    assign held_ext     = CW'(held_reg);
    assign rd_addr      = (state_reg == ST_IDLE) ? '0 : idx_inc[SW-1:0];

    assign to_wait = dup_reg || (!have_free_reg && lock_reg)
                     || (have_free_reg && lock_reg && busy_reg == max_busy_reg);
    assign store   = !dup_reg && have_free_reg && lock_reg && busy_reg != max_busy_reg;
    assign mem_wr  = (state_reg == ST_DECIDE) && out_free
                     && (mode_reg == MODE_KEYED) && store;

    always_comb
    begin
        wl_status  = ST_REFUSE;
        wl_arm     = 1'b0;
        wl_waiting = waiting_reg;
        if (wait_time_reg != '0)
        begin
            if (wait_time_reg < wait_timeout_reg)
            begin
                wl_status = ST_RETRY;
                wl_arm    = 1'b1;
            end
            else
            begin
                wl_status  = ST_GIVEUP;
                wl_waiting = (waiting_reg == '0) ? '0 : waiting_reg - WAIT_W'(1);
            end
        end
        else if (wait_timeout_reg == '0)
        begin
            wl_status = ST_GIVEUP;
        end
        else if (waiting_reg < max_waiting_reg)
        begin
            wl_status  = ST_RETRY;
            wl_arm     = 1'b1;
            wl_waiting = waiting_reg + WAIT_W'(1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        waiting_next   = waiting_reg;
        keyed_next     = keyed_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        seen_next      = seen_reg;
        dup_next       = dup_reg;
        have_free_next = have_free_reg;
        free_next      = free_reg;
        out_valid_next = out_valid_reg && !m_tready;
        status_next    = status_reg;
        slot_next      = slot_reg;
        arm_next       = arm_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    idx_next       = '0;
                    seen_next      = '0;
                    dup_next       = 1'b0;
                    have_free_next = 1'b0;
                    free_next      = '0;
                    state_next     = (s_tuser == MODE_KEYED) ? ST_SCAN : ST_DECIDE;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg >= limit)
                begin
                    state_next = ST_DECIDE;
                end
                else if (hit)
                begin
                    dup_next   = 1'b1;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    seen_next = seen_step;
                    if (!occ_cur && !have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_next      = idx_reg[SW-1:0];
                    end
                    if (seen_step == CW'(keyed_reg))
                    begin
                        if (!have_free_next && seen_step < max_busy_ext
                            && idx_inc < SLOT_COUNT_C)
                        begin
                            have_free_next = 1'b1;
                            free_next      = idx_inc[SW-1:0];
                        end
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    status_next    = ST_GRANT;
                    slot_next      = '0;
                    arm_next       = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    case (mode_reg)
                        MODE_PLAIN:
                        begin
                            if (busy_reg < max_busy_reg)
                            begin
                                busy_next = (busy_reg >= CNT6_MAX) ? CNT6_MAX
                                            : busy_reg + CNT6_W'(1);
                                if (wait_time_reg != '0)
                                begin
                                    waiting_next = (waiting_reg == '0) ? '0
                                                   : waiting_reg - WAIT_W'(1);
                                end
                            end
                            else
                            begin
                                status_next  = wl_status;
                                arm_next     = wl_arm;
                                waiting_next = wl_waiting;
                            end
                        end
                        MODE_KEYED:
                        begin
                            if (to_wait)
                            begin
                                status_next  = wl_status;
                                arm_next     = wl_arm;
                                waiting_next = wl_waiting;
                            end
                            else if (store)
                            begin
                                occ_next[free_reg] = 1'b1;
                                slot_next  = HELD_W'(CW'(free_reg));
                                keyed_next = (keyed_reg >= CNT6_MAX) ? CNT6_MAX
                                             : keyed_reg + CNT6_W'(1);
                                busy_next  = (busy_reg >= CNT6_MAX) ? CNT6_MAX
                                             : busy_reg + CNT6_W'(1);
                            end
                        end
                        MODE_RELEASE:
                        begin
                            if (key_table_en_reg)
                            begin
                                if (held_ext < SLOT_COUNT_C)
                                begin
                                    occ_next[held_ext[SW-1:0]] = 1'b0;
                                end
                                keyed_next = (keyed_reg == '0) ? '0
                                             : keyed_reg - CNT6_W'(1);
                            end
                            busy_next = (busy_reg == '0) ? '0 : busy_reg - CNT6_W'(1);
                        end
                        default:
                        begin
                            status_next = ST_REFUSE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            max_busy_reg     <= '0;
            max_waiting_reg  <= '0;
            wait_timeout_reg <= '0;
            key_table_en_reg <= 1'b0;
            busy_reg         <= '0;
            waiting_reg      <= '0;
            keyed_reg        <= '0;
            occ_reg          <= '{default: 1'b0};
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            waiting_reg   <= waiting_next;
            keyed_reg     <= keyed_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    REG_MAX_BUSY:     max_busy_reg     <= cfg_wdata[CNT6_W-1:0];
                    REG_MAX_WAITING:  max_waiting_reg  <= cfg_wdata[WAIT_W-1:0];
                    REG_WAIT_TIMEOUT: wait_timeout_reg <= cfg_wdata[WAIT_W-1:0];
                    REG_KEY_TABLE_EN: key_table_en_reg <= cfg_wdata[0];
                    default:          max_busy_reg     <= max_busy_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        seen_reg      <= seen_next;
        dup_reg       <= dup_next;
        have_free_reg <= have_free_next;
        free_reg      <= free_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        arm_reg       <= arm_next;
        if (s_tvalid && s_tready)
        begin
            mode_reg      <= s_tuser[MODE_W-1:0];
            key_high_reg  <= s_tdata[63:0];
            key_low_reg   <= s_tdata[127:64];
            lock_reg      <= s_tdata[128];
            wait_time_reg <= s_tdata[144:129];
            held_reg      <= s_tdata[149:145];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            key_mem[free_reg] <= {key_high_reg, key_low_reg};
        end
        rd_key_reg <= key_mem[rd_addr];
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7] == (m_tdata[1:0] == ST_RETRY)))
        else $error("Retry timer flag disagrees with status.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Block ready again right after a transaction.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= limit))
        else $error("Key scan ran past its limit.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> out_valid_reg)
        else $error("Pending result dropped.");
`endif

endmodule
